// File: hw/rtl/hcbd_pkg.sv
// Shared types, constants and helper functions of the chunked body decoder.
package hcbd_pkg;

  // Default parameter values
  localparam int HEADER_KEEP_DEF  = 255;
  localparam int SIZE_DIGITS_DEF  = 14;
  localparam int REMAIN_WIDTH_DEF = 31;

  // Character codes
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_C  = 8'h63;

  // Blank line that ends the header, newest byte in the low byte
  localparam logic [31:0] HEADER_END = {CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};

  // Keyword "chunked": last index of its characters
  localparam logic [2:0] KEY_LAST = 3'd6;

  // Body parse phase
  typedef enum logic [1:0] {
    PH_SIZE_LINE = 2'd0,
    PH_DATA      = 2'd1,
    PH_CRLF      = 2'd2,
    PH_DONE      = 2'd3
  } phase_t;

  // One result word
  typedef struct packed {
    logic [7:0] data;
    logic       fwd;
    logic       hdr;
    logic       chk;
    logic       done;
  } result_t;

  // Hex digit lookup: valid flag and value
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Character of the keyword "chunked" at a given position
  function automatic logic [7:0] key_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h63; // c
      3'd1:    ch = 8'h68; // h
      3'd2:    ch = 8'h75; // u
      3'd3:    ch = 8'h6E; // n
      3'd4:    ch = 8'h6B; // k
      3'd5:    ch = 8'h65; // e
      3'd6:    ch = 8'h64; // d
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Decode one hex digit of either case
  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (ch inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = 4'(ch - 8'h30);
    end else if (ch inside {[8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = 4'(ch - 8'h57);
    end else if (ch inside {[8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.val = 4'(ch - 8'h37);
    end
    return h;
  endfunction

endpackage

// File: hw/rtl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder: header scan, chunk-size parse and data forwarding.
//
// The decoder takes one response byte per cycle while in_stall is low and returns one
// result word per byte. Every byte is handled by a single register update of
// the parser state; the result goes to an output register backed by one skid register,
// so in_stall rises only when both hold a word the consumer has not taken yet. A byte
// with start_of_message set clears all parser state and is then handled as the first
// byte of a new response. "chunked" is searched in the first HEADER_KEEP header bytes,
// chunk sizes keep at most SIZE_DIGITS hex digits and saturate at 2^REMAIN_WIDTH - 1.
module http_chunked_body_decoder #(
  parameter int HEADER_KEEP  = hcbd_pkg::HEADER_KEEP_DEF,
  parameter int SIZE_DIGITS  = hcbd_pkg::SIZE_DIGITS_DEF,
  parameter int REMAIN_WIDTH = hcbd_pkg::REMAIN_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       start_of_message,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       header_complete,
  output logic       chunked_mode,
  output logic       body_complete
);

  localparam int HCW = $clog2(HEADER_KEEP + 1);
  localparam int DCW = $clog2(SIZE_DIGITS + 1);
  localparam int RW  = REMAIN_WIDTH;

  // Parser state
  logic                   header_seen, header_seen_next;
  logic [31:0]            tail_window, tail_window_next;
  logic [HCW-1:0]         kept_count, kept_count_next;
  logic [2:0]             key_prog, key_prog_next;
  logic                   chunked_flag, chunked_flag_next;
  hcbd_pkg::phase_t       phase, phase_next;
  logic [RW-1:0]          size_accum, size_accum_next;
  logic [DCW-1:0]         digit_count, digit_count_next;
  logic [RW-1:0]          remaining, remaining_next;

  // State seen by this byte, after an optional start clear
  logic                   cur_hs;
  logic [31:0]            cur_tail;
  logic [HCW-1:0]         cur_kept;
  logic [2:0]             cur_prog;
  logic                   cur_chk;
  hcbd_pkg::phase_t       cur_phase;
  logic [RW-1:0]          cur_size;
  logic [DCW-1:0]         cur_digits;
  logic [RW-1:0]          cur_rem;

  logic                   fwd;
  hcbd_pkg::hex_t         hex;
  logic [RW-1:0]          rem_dec;
  hcbd_pkg::result_t      res;

  // Output register and skid register
  hcbd_pkg::result_t      out_reg, skid_reg;
  logic                   out_full, skid_full;

  logic in_accept;
  logic out_accept;

  assign in_stall   = skid_full;
  assign in_accept  = in_valid & ~skid_full;
  assign out_accept = out_full & ~result_stall;

  // Clear state on start of message
  always_comb begin
    cur_hs     = header_seen & ~start_of_message;
    cur_tail   = start_of_message ? '0 : tail_window;
    cur_kept   = start_of_message ? '0 : kept_count;
    cur_prog   = start_of_message ? '0 : key_prog;
    cur_chk    = chunked_flag & ~start_of_message;
    cur_phase  = start_of_message ? hcbd_pkg::PH_SIZE_LINE : phase;
    cur_size   = start_of_message ? '0 : size_accum;
    cur_digits = start_of_message ? '0 : digit_count;
    cur_rem    = start_of_message ? '0 : remaining;
  end

  assign hex     = hcbd_pkg::hex_decode(in_byte);
  assign rem_dec = (cur_rem != '0) ? cur_rem - RW'(1) : '0;

  // Next state and result for one byte
  always_comb begin
    header_seen_next  = cur_hs;
    tail_window_next  = cur_tail;
    kept_count_next   = cur_kept;
    key_prog_next     = cur_prog;
    chunked_flag_next = cur_chk;
    phase_next        = cur_phase;
    size_accum_next   = cur_size;
    digit_count_next  = cur_digits;
    remaining_next    = cur_rem;
    fwd               = 1'b0;

    if (!cur_hs) begin
      // header: keyword search over the first bytes, blank line detection on every byte
      if (cur_kept < HCW'(HEADER_KEEP)) begin
        kept_count_next = cur_kept + HCW'(1);
        if (!cur_chk) begin
          if (in_byte == hcbd_pkg::key_char(cur_prog)) begin
            if (cur_prog == hcbd_pkg::KEY_LAST) begin
              chunked_flag_next = 1'b1;
              key_prog_next     = '0;
            end else begin
              key_prog_next = cur_prog + 3'd1;
            end
          end else begin
            key_prog_next = (in_byte == hcbd_pkg::CHAR_C) ? 3'd1 : 3'd0;
          end
        end
      end
      tail_window_next = {cur_tail[23:0], in_byte};
      if (tail_window_next == hcbd_pkg::HEADER_END) begin
        header_seen_next = 1'b1;
      end
    end else if (!cur_chk) begin
      fwd = 1'b1;
    end else begin
      case (cur_phase)
        hcbd_pkg::PH_SIZE_LINE: begin
          if (in_byte == hcbd_pkg::CHAR_LF) begin
            size_accum_next  = '0;
            digit_count_next = '0;
            if (cur_size == '0) begin
              phase_next = hcbd_pkg::PH_DONE;
            end else begin
              remaining_next = cur_size;
              phase_next     = hcbd_pkg::PH_DATA;
            end
          end else if (hex.ok && (cur_digits < DCW'(SIZE_DIGITS))) begin
            digit_count_next = cur_digits + DCW'(1);
            // saturate once another digit would overflow
            if (|cur_size[RW-1:RW-4]) begin
              size_accum_next = '1;
            end else begin
              size_accum_next = {cur_size[RW-5:0], hex.val};
            end
          end
        end
        hcbd_pkg::PH_DATA: begin
          fwd            = 1'b1;
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = hcbd_pkg::PH_CRLF;
          end
        end
        hcbd_pkg::PH_CRLF: begin
          if (in_byte == hcbd_pkg::CHAR_LF) begin
            phase_next = hcbd_pkg::PH_SIZE_LINE;
          end
        end
        default: begin
        end
      endcase
    end

    res.data = fwd ? in_byte : 8'h00;
    res.fwd  = fwd;
    res.hdr  = header_seen_next;
    res.chk  = header_seen_next & chunked_flag_next;
    res.done = header_seen_next & chunked_flag_next & (phase_next == hcbd_pkg::PH_DONE);
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      header_seen  <= 1'b0;
      tail_window  <= '0;
      kept_count   <= '0;
      key_prog     <= '0;
      chunked_flag <= 1'b0;
      phase        <= hcbd_pkg::PH_SIZE_LINE;
      size_accum   <= '0;
      digit_count  <= '0;
      remaining    <= '0;
    end else if (in_accept) begin
      header_seen  <= header_seen_next;
      tail_window  <= tail_window_next;
      kept_count   <= kept_count_next;
      key_prog     <= key_prog_next;
      chunked_flag <= chunked_flag_next;
      phase        <= phase_next;
      size_accum   <= size_accum_next;
      digit_count  <= digit_count_next;
      remaining    <= remaining_next;
    end
  end

  // Output register with skid: hold on stall, drain skid when output is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (in_accept) begin
        if (!out_full || !result_stall) begin
          out_full <= 1'b1;
        end else begin
          skid_full <= 1'b1;
        end
      end else if (out_accept) begin
        out_full  <= skid_full;
        skid_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!out_full || !result_stall) begin
        out_reg <= res;
      end else begin
        skid_reg <= res;
      end
    end else if (out_accept && skid_full) begin
      out_reg <= skid_reg;
    end
  end

  assign result_valid    = out_full;
  assign out_byte        = out_reg.data;
  assign out_valid       = out_reg.fwd;
  assign header_complete = out_reg.hdr;
  assign chunked_mode    = out_reg.chk;
  assign body_complete   = out_reg.done;

  // Skid holds a word only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_full)
    else $error("skid register full while output register empty");

  // A finished body implies chunked mode after the header
  a_done_needs_chunked: assert property (@(posedge clk) disable iff (rst)
    (result_valid && body_complete) |-> (chunked_mode && header_complete))
    else $error("body complete without chunked mode");

  // Forwarded bytes only after the header has ended
  a_fwd_after_header: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_valid) |-> header_complete)
    else $error("byte forwarded before header end");

endmodule
